### hw/rtl/sfmi_pkg.sv
// Package for the season flat-map indexer: shared types, codes and constants.
// No dependencies; every other file of the block but sfmi_win_ram refers to it by scoped names.
`timescale 1ns / 1ps

package sfmi_pkg;

  // Default number of season window entries.
  localparam int SFMI_MAX_SEASONS = 16;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GRID_WIDTH       = 3'd0;
  localparam logic [2:0] CFG_CHIPS_PER_FILTER = 3'd1;
  localparam logic [2:0] CFG_FLATS_PER_SEASON = 3'd2;
  localparam logic [2:0] CFG_SEASONS_IN_USE   = 3'd3;
  localparam logic [2:0] CFG_MISS_LIMIT       = 3'd4;

  // Configuration reset values.
  localparam logic [3:0]  RST_GRID_WIDTH       = 4'd8;
  localparam logic [11:0] RST_CHIPS_PER_FILTER = 12'd64;
  localparam logic [15:0] RST_FLATS_PER_SEASON = 16'd640;
  localparam logic [4:0]  RST_SEASONS_IN_USE   = 5'd0;
  localparam logic [7:0]  RST_MISS_LIMIT       = 8'd100;

  // Result status codes.
  localparam logic [2:0] STAT_LOADED    = 3'd0;
  localparam logic [2:0] STAT_HEADER    = 3'd1;
  localparam logic [2:0] STAT_UNKNOWN   = 3'd2;
  localparam logic [2:0] STAT_MAPPED    = 3'd3;
  localparam logic [2:0] STAT_NO_SEASON = 3'd4;
  localparam logic [2:0] STAT_HALTED    = 3'd5;

  // Photometry code ranges of the two cameras.
  localparam logic [15:0] CAM1_CODE_LO = 16'd10000;
  localparam logic [15:0] CAM1_CODE_HI = 16'd10576;
  localparam logic [15:0] CAM2_CODE_LO = 16'd20000;
  localparam logic [15:0] CAM2_CODE_HI = 16'd26111;

  // Second camera column offset and filter stride.
  localparam logic [31:0] CAM2_COL_BASE     = 32'd20000;
  localparam logic [31:0] CAM2_FILTER_SCALE = 32'd1000;

  // Divide by ten for 16-bit values: q = (x * RECIP10) >> RECIP10_SHIFT is exact.
  localparam logic [16:0] RECIP10       = 17'd52429;
  localparam int          RECIP10_SHIFT = 19;

  localparam logic [8:0] MISS_MAX = 9'd511;

  typedef enum logic [1:0] {
    CAM_NONE   = 2'd0,
    CAM_FIRST  = 2'd1,
    CAM_SECOND = 2'd2
  } cam_kind_t;

  // Request to the index arithmetic unit.
  typedef struct packed {
    logic        start;
    logic [15:0] code;
    cam_kind_t   kind;
    logic [3:0]  grid_width;
    logic [11:0] chips_per_filter;
  } calc_req_t;

  // Answer of the index arithmetic unit: index without the season term.
  typedef struct packed {
    logic        done;
    logic [31:0] part;
  } calc_rsp_t;

endpackage

### hw/rtl/sfmi_win_ram.sv
// Season window memory: one begin/end pair per entry, registered read port.
// Plain synchronous RAM, no dependencies.
`timescale 1ns / 1ps

module sfmi_win_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sfmi_seq_calc.sv
// Index arithmetic unit: decodes the decimal digits of the photometry code one
// per cycle and sums the chip and filter terms. Depends on sfmi_pkg.
`timescale 1ns / 1ps

module sfmi_seq_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  sfmi_pkg::calc_req_t req,
  output sfmi_pkg::calc_rsp_t rsp
);

  localparam logic [2:0] STEP_DIGIT_LAST = 3'd3;
  localparam logic [2:0] STEP_BASE       = 3'd4;
  localparam logic [2:0] STEP_FILTER     = 3'd5;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [15:0]         x_r, x_nxt;
  logic [15:0]         code_r;
  sfmi_pkg::cam_kind_t kind_r;
  logic [3:0]          grid_r;
  logic [11:0]         cpf_r;
  logic [3:0]          dig_r [4];
  logic [31:0]         part_r, part_nxt;

  logic [32:0] recip_prod;
  logic [15:0] quot;
  logic [15:0] rem16;
  logic [3:0]  digit;
  logic [7:0]  row_prod;
  logic [3:0]  filt;
  logic [15:0] filt_prod;
  logic [31:0] cam2_col;

  // One decimal digit per cycle; the quotient feeds the next step.
  assign recip_prod = {17'd0, x_r} * {16'd0, sfmi_pkg::RECIP10};
  assign quot       = 16'(recip_prod >> sfmi_pkg::RECIP10_SHIFT);
  assign rem16      = x_r - ((quot << 3) + (quot << 1));
  assign digit      = rem16[3:0];

  assign row_prod  = {4'd0, dig_r[0]} * {4'd0, grid_r};
  assign filt      = (kind_r == sfmi_pkg::CAM_FIRST) ? dig_r[2] : dig_r[3];
  assign filt_prod = {12'd0, filt} * {4'd0, cpf_r};
  assign cam2_col  = {16'd0, code_r} - sfmi_pkg::CAM2_COL_BASE
                   - ({28'd0, dig_r[3]} * sfmi_pkg::CAM2_FILTER_SCALE);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    x_nxt    = x_r;
    part_nxt = part_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = 3'd0;
      x_nxt    = req.code;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      if (step_r <= STEP_DIGIT_LAST) begin
        x_nxt = quot;
      end else if (step_r == STEP_BASE) begin
        if (kind_r == sfmi_pkg::CAM_FIRST) begin
          part_nxt = {28'd0, dig_r[1]} + {24'd0, row_prod};
        end else begin
          part_nxt = cam2_col;
        end
      end else if (step_r == STEP_FILTER) begin
        part_nxt = part_r + {16'd0, filt_prod};
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    part_r <= part_nxt;
    if (req.start) begin
      code_r <= req.code;
      kind_r <= req.kind;
      grid_r <= req.grid_width;
      cpf_r  <= req.chips_per_filter;
    end
    if (busy_r && !req.start && step_r <= STEP_DIGIT_LAST) begin
      dig_r[step_r[1:0]] <= digit;
    end
  end

  assign rsp.done = done_r;
  assign rsp.part = part_r;

endmodule

### hw/rtl/season_flat_map_indexer.sv
// Season flat-map indexer top level; uses sfmi_pkg, sfmi_win_ram and sfmi_seq_calc.
// A load, halted, header or unknown-camera item goes from evaluation straight to the result;
// an image that misses all searched windows has its result when the window walk ends, and a
// mapped image when index math and window walk have both ended. One transaction is in work
// at a time; the next is accepted once the result enters the output register. Sync reset
// sets control, miss, halt and config state to reset values; data and window RAM are kept.
`timescale 1ns / 1ps

module season_flat_map_indexer #(
  parameter int MAX_SEASONS = sfmi_pkg::SFMI_MAX_SEASONS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic        in_first_of_batch,
  input  logic [15:0] in_photo_code,
  input  logic [31:0] in_obs_time,
  input  logic [3:0]  in_season_index,
  input  logic [31:0] in_season_begin,
  input  logic [31:0] in_season_end,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_map_id,
  output logic [2:0]  out_status,
  output logic [3:0]  out_season_hit,
  output logic [8:0]  out_missed_total,
  output logic        out_halted
);

  localparam int AW = (MAX_SEASONS > 1) ? $clog2(MAX_SEASONS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_INDEX  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [3:0]  grid_r;
  logic [11:0] cpf_r;
  logic [15:0] fps_r;
  logic [4:0]  seasons_r;
  logic [7:0]  limit_r;

  // Captured transaction
  logic        it_action_r;
  logic        it_first_r;
  logic [15:0] it_code_r;
  logic [31:0] it_time_r;
  logic [3:0]  it_sidx_r;
  logic [31:0] it_begin_r;
  logic [31:0] it_end_r;

  // Persistent state
  sfmi_pkg::cam_kind_t cam_r, cam_nxt;
  logic [8:0] miss_r, miss_nxt;
  logic       halt_r, halt_nxt;

  // Window walk
  logic [4:0] rd_cnt_r, rd_cnt_nxt;
  logic       cmp_vld_r, cmp_vld_nxt;
  logic [4:0] cmp_idx_r, cmp_idx_nxt;
  logic [4:0] hit_r, hit_nxt;

  // Result being built
  logic [31:0] res_map_r, res_map_nxt;
  logic [2:0]  res_status_r, res_status_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_map_r;
  logic [2:0]  out_status_r;
  logic [3:0]  out_hit_r;
  logic [8:0]  out_missed_r;
  logic        out_halted_r;
  logic        out_load;

  // RAM and arithmetic unit
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_rdata;
  logic [31:0]   win_start, win_stop;
  sfmi_pkg::calc_req_t calc_req;
  sfmi_pkg::calc_rsp_t calc_rsp;

  logic                in_accept;
  logic [4:0]          n_lim;
  sfmi_pkg::cam_kind_t kind_base, kind_new;
  logic                in_window;
  logic                walk_end;
  logic [8:0]          miss_inc;
  logic [20:0]         season_prod;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // Entries past the RAM depth are never searched.
  assign n_lim = (32'(seasons_r) > 32'(MAX_SEASONS)) ? 5'(MAX_SEASONS) : seasons_r;

  assign kind_base = it_first_r ? sfmi_pkg::CAM_NONE : cam_r;
  always_comb begin
    if (it_code_r >= sfmi_pkg::CAM1_CODE_LO && it_code_r <= sfmi_pkg::CAM1_CODE_HI) begin
      kind_new = sfmi_pkg::CAM_FIRST;
    end else if (it_code_r >= sfmi_pkg::CAM2_CODE_LO &&
                 it_code_r <= sfmi_pkg::CAM2_CODE_HI) begin
      kind_new = sfmi_pkg::CAM_SECOND;
    end else begin
      kind_new = kind_base;
    end
  end

  assign win_start = mem_rdata[63:32];
  assign win_stop  = mem_rdata[31:0];
  assign in_window = cmp_vld_r && (it_time_r >= win_start) && (it_time_r <= win_stop);
  assign walk_end  = (n_lim == 5'd0) ||
                     (cmp_vld_r && (({1'b0, cmp_idx_r} + 6'd1) == {1'b0, n_lim}));
  assign miss_inc  = (miss_r == sfmi_pkg::MISS_MAX) ? miss_r : miss_r + 9'd1;
  assign season_prod = {16'd0, hit_r} * {5'd0, fps_r};

  assign mem_waddr = AW'(it_sidx_r);
  assign mem_raddr = AW'(rd_cnt_r);
  assign out_load  = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    cam_nxt        = cam_r;
    miss_nxt       = miss_r;
    halt_nxt       = halt_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    res_map_nxt    = res_map_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    calc_req.start            = 1'b0;
    calc_req.code             = it_code_r;
    calc_req.kind             = kind_new;
    calc_req.grid_width       = grid_r;
    calc_req.chips_per_filter = cpf_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_map_nxt = 32'd0;
        hit_nxt     = 5'd0;
        state_nxt   = ST_RESULT;
        priority if (halt_r) begin
          res_status_nxt = sfmi_pkg::STAT_HALTED;
        end else if (!it_action_r) begin
          mem_we         = (32'(it_sidx_r) < 32'(MAX_SEASONS));
          res_status_nxt = sfmi_pkg::STAT_LOADED;
        end else begin
          if (it_first_r) begin
            miss_nxt = 9'd0;
          end
          if (it_code_r == 16'd0) begin
            cam_nxt        = kind_base;
            res_status_nxt = sfmi_pkg::STAT_HEADER;
          end else begin
            cam_nxt = kind_new;
            if (kind_new == sfmi_pkg::CAM_NONE) begin
              res_status_nxt = sfmi_pkg::STAT_UNKNOWN;
            end else begin
              calc_req.start = 1'b1;
              rd_cnt_nxt     = 5'd0;
              cmp_vld_nxt    = 1'b0;
              state_nxt      = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // Reads are issued one per cycle; each compare sees the entry read
        // in the cycle before.
        mem_re      = (rd_cnt_r < n_lim);
        cmp_vld_nxt = mem_re;
        cmp_idx_nxt = rd_cnt_r;
        if (mem_re) begin
          rd_cnt_nxt = rd_cnt_r + 5'd1;
        end
        priority if (in_window) begin
          hit_nxt   = cmp_idx_r;
          halt_nxt  = (miss_r > {1'b0, limit_r});
          state_nxt = ST_INDEX;
        end else if (walk_end) begin
          miss_nxt       = miss_inc;
          halt_nxt       = (miss_inc > {1'b0, limit_r});
          res_status_nxt = sfmi_pkg::STAT_NO_SEASON;
          state_nxt      = ST_RESULT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_INDEX: begin
        if (calc_rsp.done) begin
          res_map_nxt    = calc_rsp.part + {11'd0, season_prod} + 32'd1;
          res_status_nxt = sfmi_pkg::STAT_MAPPED;
          state_nxt      = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cam_r       <= sfmi_pkg::CAM_NONE;
      miss_r      <= 9'd0;
      halt_r      <= 1'b0;
      rd_cnt_r    <= 5'd0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cam_r       <= cam_nxt;
      miss_r      <= miss_nxt;
      halt_r      <= halt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r    <= sfmi_pkg::RST_GRID_WIDTH;
      cpf_r     <= sfmi_pkg::RST_CHIPS_PER_FILTER;
      fps_r     <= sfmi_pkg::RST_FLATS_PER_SEASON;
      seasons_r <= sfmi_pkg::RST_SEASONS_IN_USE;
      limit_r   <= sfmi_pkg::RST_MISS_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfmi_pkg::CFG_GRID_WIDTH:       grid_r    <= cfg_wdata[3:0];
        sfmi_pkg::CFG_CHIPS_PER_FILTER: cpf_r     <= cfg_wdata[11:0];
        sfmi_pkg::CFG_FLATS_PER_SEASON: fps_r     <= cfg_wdata;
        sfmi_pkg::CFG_SEASONS_IN_USE:   seasons_r <= cfg_wdata[4:0];
        sfmi_pkg::CFG_MISS_LIMIT:       limit_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_action_r <= in_action;
      it_first_r  <= in_first_of_batch;
      it_code_r   <= in_photo_code;
      it_time_r   <= in_obs_time;
      it_sidx_r   <= in_season_index;
      it_begin_r  <= in_season_begin;
      it_end_r    <= in_season_end;
    end
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    res_map_r    <= res_map_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_map_r    <= res_map_r;
      out_status_r <= res_status_r;
      out_hit_r    <= (res_status_r == sfmi_pkg::STAT_MAPPED) ? hit_r[3:0] : 4'd0;
      out_missed_r <= miss_r;
      out_halted_r <= halt_r;
    end
  end

  sfmi_win_ram #(
    .DEPTH (MAX_SEASONS),
    .AW    (AW),
    .DW    (64)
  ) u_win_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({it_begin_r, it_end_r}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sfmi_seq_calc u_seq_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_map_id       = out_map_r;
  assign out_status       = out_status_r;
  assign out_season_hit   = out_hit_r;
  assign out_missed_total = out_missed_r;
  assign out_halted       = out_halted_r;

endmodule

### hw/rtl/sfmi_checker.sv
// Port-level checker for the season flat-map indexer, bound to the top level.
// Depends on sfmi_pkg for the status codes.
`timescale 1ns / 1ps

module sfmi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_map_id,
  input logic [2:0]  out_status,
  input logic [3:0]  out_season_hit,
  input logic        out_halted
);

  // Only one transaction is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_map_id) && $stable(out_status)))
    else $error("stalled result changed or dropped");

  // A rejected item can only come from a halted block.
  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sfmi_pkg::STAT_HALTED) |-> out_halted)
    else $error("halted status without halt flag");

  a_no_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sfmi_pkg::STAT_MAPPED) |->
      (out_map_id == 32'd0 && out_season_hit == 4'd0))
    else $error("map or season reported for an unmapped item");

endmodule

bind season_flat_map_indexer sfmi_checker u_sfmi_checker (.*);

### tb/season_flat_map_indexer_tb.sv
// Self-checking testbench, season flat-map indexer: directed table, random batches, halt test.
// Holds its own predictor of the window search and index math; depends on sfmi_pkg and the RTL.
`timescale 1ns / 1ps

module season_flat_map_indexer_tb;

  localparam int MAX_SEASONS      = sfmi_pkg::SFMI_MAX_SEASONS;
  localparam int LIMIT_CYCLES     = 400000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 40;
  localparam int PHASES           = 8;
  localparam int PHASE_ITEMS      = 165;
  localparam int HALTED_ITEMS     = 30;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 120;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  typedef struct packed {
    logic        action;
    logic        first;
    logic [15:0] code;
    logic [31:0] obs_time;
    logic [3:0]  sidx;
    logic [31:0] sbeg;
    logic [31:0] send;
  } flat_req_t;

  typedef struct packed {
    logic [31:0] map_id;
    logic [2:0]  status;
    logic [3:0]  hit;
    logic [8:0]  missed;
    logic        halted;
  } flat_res_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    flat_req_t   req;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    flat_res_t   want;
  } steer_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic        in_first_of_batch = 1'b0;
  logic [15:0] in_photo_code = '0;
  logic [31:0] in_obs_time = '0;
  logic [3:0]  in_season_index = '0;
  logic [31:0] in_season_begin = '0;
  logic [31:0] in_season_end = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_map_id;
  logic [2:0]  out_status;
  logic [3:0]  out_season_hit;
  logic [8:0]  out_missed_total;
  logic        out_halted;

  // Predictor state and its copy of the configuration registers.
  logic [31:0]         win_lo [MAX_SEASONS];
  logic [31:0]         win_hi [MAX_SEASONS];
  sfmi_pkg::cam_kind_t cam_q = sfmi_pkg::CAM_NONE;
  logic [8:0]          miss_q = '0;
  logic                halt_q = 1'b0;
  logic [3:0]          grid_q = sfmi_pkg::RST_GRID_WIDTH;
  logic [11:0]         cpf_q = sfmi_pkg::RST_CHIPS_PER_FILTER;
  logic [15:0]         fps_q = sfmi_pkg::RST_FLATS_PER_SEASON;
  logic [4:0]          seasons_q = sfmi_pkg::RST_SEASONS_IN_USE;
  logic [7:0]          limit_q = sfmi_pkg::RST_MISS_LIMIT;

  flat_res_t  map_expect_q[$];
  steer_row_t steer_tab[$];
  int         mismatch_count = 0;
  int         maps_returned = 0;
  int         cycle_count = 0;
  bit         quiet_tail = 1'b0;

  season_flat_map_indexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_first_of_batch(in_first_of_batch),
    .in_photo_code    (in_photo_code),
    .in_obs_time      (in_obs_time),
    .in_season_index  (in_season_index),
    .in_season_begin  (in_season_begin),
    .in_season_end    (in_season_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_map_id       (out_map_id),
    .out_status       (out_status),
    .out_season_hit   (out_season_hit),
    .out_missed_total (out_missed_total),
    .out_halted       (out_halted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic flat_res_t predict_flat_map(flat_req_t r);
    flat_res_t   res;
    logic [31:0] code32, row, col, filt, seq, hit;
    int          n, j;
    bit          found;
    res = '0;
    found = 1'b0;
    hit = '0;
    code32 = {16'd0, r.code};
    if (halt_q) begin
      res.status = sfmi_pkg::STAT_HALTED;
    end else if (r.action == ACT_LOAD) begin
      if (r.sidx < MAX_SEASONS) begin
        win_lo[r.sidx] = r.sbeg;
        win_hi[r.sidx] = r.send;
      end
      res.status = sfmi_pkg::STAT_LOADED;
    end else begin
      if (r.first) begin
        miss_q = '0;
        cam_q = sfmi_pkg::CAM_NONE;
      end
      if (r.code == 16'd0) begin
        res.status = sfmi_pkg::STAT_HEADER;
      end else begin
        if (r.code >= sfmi_pkg::CAM1_CODE_LO && r.code <= sfmi_pkg::CAM1_CODE_HI)
          cam_q = sfmi_pkg::CAM_FIRST;
        else if (r.code >= sfmi_pkg::CAM2_CODE_LO && r.code <= sfmi_pkg::CAM2_CODE_HI)
          cam_q = sfmi_pkg::CAM_SECOND;
        if (cam_q == sfmi_pkg::CAM_NONE) begin
          res.status = sfmi_pkg::STAT_UNKNOWN;
        end else begin
          n = (seasons_q > MAX_SEASONS) ? MAX_SEASONS : int'(seasons_q);
          for (j = 0; j < n && !found; j++) begin
            if (r.obs_time >= win_lo[j] && r.obs_time <= win_hi[j]) begin
              found = 1'b1;
              hit = 32'(j);
            end
          end
          if (found) begin
            if (cam_q == sfmi_pkg::CAM_FIRST) begin
              row = code32 % 32'd10;
              col = (code32 / 32'd10) % 32'd10;
              filt = (code32 / 32'd100) % 32'd10;
              seq = col + row * 32'(grid_q) + filt * 32'(cpf_q) + hit * 32'(fps_q);
            end else begin
              // A code below the second camera base gives a wrapped, huge column.
              filt = (code32 / sfmi_pkg::CAM2_FILTER_SCALE) % 32'd10;
              col = code32 - sfmi_pkg::CAM2_COL_BASE - filt * sfmi_pkg::CAM2_FILTER_SCALE;
              seq = col + filt * 32'(cpf_q) + hit * 32'(fps_q);
            end
            if (miss_q > limit_q) halt_q = 1'b1;
            res.map_id = seq + 32'd1;
            res.status = sfmi_pkg::STAT_MAPPED;
            res.hit = hit[3:0];
          end else begin
            if (miss_q < sfmi_pkg::MISS_MAX) miss_q++;
            if (miss_q > limit_q) halt_q = 1'b1;
            res.status = sfmi_pkg::STAT_NO_SEASON;
          end
        end
      end
    end
    res.missed = miss_q;
    res.halted = halt_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    flat_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      maps_returned++;
      if (map_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_status), 32'd0);
      end else begin
        want = map_expect_q.pop_front();
        if (out_map_id !== want.map_id) report_mismatch("map_id", out_map_id, want.map_id);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_season_hit !== want.hit)
          report_mismatch("season_hit", 32'(out_season_hit), 32'(want.hit));
        if (out_missed_total !== want.missed)
          report_mismatch("missed_total", 32'(out_missed_total), 32'(want.missed));
        if (out_halted !== want.halted)
          report_mismatch("halted", 32'(out_halted), 32'(want.halted));
      end
    end
  end

  // Result side: random stall bursts, calm stretches, and one long hold-off that
  // backs the block up while the sender keeps offering transactions.
  initial begin : receiver
    int burst, stretch;
    bit calm, held_long;
    burst = 0;
    stretch = 0;
    calm = 1'b0;
    held_long = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(40, 300);
        calm = ($urandom_range(0, 2) == 0);
      end else begin
        stretch--;
      end
      if (!held_long && maps_returned >= LONG_HOLD_AT) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer(flat_req_t r, bit typed = 1'b0, flat_res_t want = '0);
    flat_res_t guess;
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= r.action;
    in_first_of_batch <= r.first;
    in_photo_code <= r.code;
    in_obs_time <= r.obs_time;
    in_season_index <= r.sidx;
    in_season_begin <= r.sbeg;
    in_season_end <= r.send;
    do @(posedge clk); while (in_stall);
    guess = predict_flat_map(r);
    map_expect_q.push_back(typed ? want : guess);
  endtask

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (map_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bits above a register's width are sometimes filled with noise; the block drops them.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    logic [15:0] keep;
    case (idx)
      sfmi_pkg::CFG_GRID_WIDTH:       keep = 16'h000F;
      sfmi_pkg::CFG_CHIPS_PER_FILTER: keep = 16'h0FFF;
      sfmi_pkg::CFG_SEASONS_IN_USE:   keep = 16'h001F;
      sfmi_pkg::CFG_MISS_LIMIT:       keep = 16'h00FF;
      default:                        keep = 16'hFFFF;
    endcase
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    if ($urandom_range(0, 1) == 1) cfg_wdata <= (val & keep) | (16'($urandom) & ~keep);
    else cfg_wdata <= val & keep;
    @(posedge clk);
    case (idx)
      sfmi_pkg::CFG_GRID_WIDTH:       grid_q = val[3:0];
      sfmi_pkg::CFG_CHIPS_PER_FILTER: cpf_q = val[11:0];
      sfmi_pkg::CFG_FLATS_PER_SEASON: fps_q = val;
      sfmi_pkg::CFG_SEASONS_IN_USE:   seasons_q = val[4:0];
      sfmi_pkg::CFG_MISS_LIMIT:       limit_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic steer_row_t image_row(logic first, logic [15:0] code, logic [31:0] t);
    steer_row_t row;
    row.kind = ROW_PREDICT;
    row.req = '0;
    row.req.action = ACT_MAP;
    row.req.first = first;
    row.req.code = code;
    row.req.obs_time = t;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.want = '0;
    return row;
  endfunction

  function automatic steer_row_t load_row(logic [3:0] idx, logic [31:0] lo, logic [31:0] hi);
    steer_row_t row;
    row = image_row(1'b0, 16'd0, 32'd0);
    row.req.action = ACT_LOAD;
    row.req.sidx = idx;
    row.req.sbeg = lo;
    row.req.send = hi;
    return row;
  endfunction

  function automatic steer_row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    steer_row_t row;
    row = image_row(1'b0, 16'd0, 32'd0);
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic steer_row_t typed(steer_row_t row, logic [31:0] map, logic [2:0] status,
                                       logic [8:0] missed);
    row.kind = ROW_TYPED;
    row.want = '0;
    row.want.map_id = map;
    row.want.status = status;
    row.want.missed = missed;
    return row;
  endfunction

  function automatic logic [63:0] random_window();
    logic [31:0] lo, hi;
    case ($urandom_range(0, 15))
      0, 1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = 32'd0;
        hi = 32'hFFFF_FFFF;
      end
      3: begin
        // Empty window: end one below begin.
        lo = $urandom_range(1, 30000);
        hi = lo - 32'd1;
      end
      default: begin
        lo = $urandom_range(0, 28000);
        hi = lo + $urandom_range(0, 3000);
      end
    endcase
    return {lo, hi};
  endfunction

  function automatic logic [31:0] random_obs_time();
    logic [31:0] lo, hi, t;
    int          j;
    j = $urandom_range(0, MAX_SEASONS - 1);
    lo = win_lo[j];
    hi = win_hi[j];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if (lo <= hi) t = lo + 32'(64'($urandom) % (64'(hi - lo) + 64'd1));
        else t = $urandom;
      end
      5, 6: t = $urandom_range(0, 30000);
      7: begin
        case ($urandom_range(0, 3))
          0: t = lo;
          1: t = hi;
          2: t = lo - 32'd1;
          default: t = hi + 32'd1;
        endcase
      end
      default: t = $urandom;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] random_code(bit lead);
    logic [15:0] code;
    case (lead ? $urandom_range(0, 5) : $urandom_range(0, 9))
      0, 1, 2: code = 16'($urandom_range(sfmi_pkg::CAM1_CODE_LO, sfmi_pkg::CAM1_CODE_HI));
      3, 4, 5: code = 16'($urandom_range(sfmi_pkg::CAM2_CODE_LO, sfmi_pkg::CAM2_CODE_HI));
      6: code = 16'd0;
      7: begin
        case ($urandom_range(0, 5))
          0: code = sfmi_pkg::CAM1_CODE_LO - 16'd1;
          1: code = sfmi_pkg::CAM1_CODE_HI + 16'd1;
          2: code = sfmi_pkg::CAM2_CODE_LO - 16'd1;
          3: code = sfmi_pkg::CAM2_CODE_HI + 16'd1;
          4: code = 16'hFFFF;
          default: code = 16'd1;
        endcase
      end
      default: code = 16'($urandom);
    endcase
    return code;
  endfunction

  // A batch opens with a camera image that clears the batch; the rest mixes
  // images, window loads and some noise.
  function automatic flat_req_t random_request(bit lead);
    flat_req_t r;
    r.action = ($urandom_range(0, 99) < 14) ? ACT_LOAD : ACT_MAP;
    r.first = lead ? 1'b1 : ($urandom_range(0, 39) == 0);
    r.code = random_code(lead);
    r.obs_time = random_obs_time();
    r.sidx = 4'($urandom_range(0, MAX_SEASONS - 1));
    {r.sbeg, r.send} = random_window();
    if (lead) r.action = ACT_MAP;
    if ($urandom_range(0, 11) == 0) begin
      r.first = 1'($urandom_range(0, 1));
      r.code = 16'($urandom);
    end
    return r;
  endfunction

  task automatic configure_phase(int p);
    logic [15:0] seasons;
    if (p == 0) begin
      write_reg(sfmi_pkg::CFG_GRID_WIDTH, 16'd15);
      write_reg(sfmi_pkg::CFG_CHIPS_PER_FILTER, 16'd4095);
      write_reg(sfmi_pkg::CFG_FLATS_PER_SEASON, 16'hFFFF);
      write_reg(sfmi_pkg::CFG_SEASONS_IN_USE, 16'd16);
      write_reg(sfmi_pkg::CFG_MISS_LIMIT, 16'd255);
    end else if (p == 1) begin
      write_reg(sfmi_pkg::CFG_GRID_WIDTH, 16'd0);
      write_reg(sfmi_pkg::CFG_CHIPS_PER_FILTER, 16'd0);
      write_reg(sfmi_pkg::CFG_FLATS_PER_SEASON, 16'd0);
      write_reg(sfmi_pkg::CFG_SEASONS_IN_USE, 16'd0);
      write_reg(sfmi_pkg::CFG_MISS_LIMIT, 16'd1);
    end else begin
      case ($urandom_range(0, 7))
        0: seasons = 16'd1;
        1: seasons = 16'd16;
        // Values past the table size search only the table.
        2: seasons = 16'($urandom_range(17, 31));
        default: seasons = 16'($urandom_range(0, 16));
      endcase
      write_reg(sfmi_pkg::CFG_GRID_WIDTH, 16'($urandom_range(0, 15)));
      write_reg(sfmi_pkg::CFG_CHIPS_PER_FILTER, 16'($urandom_range(0, 4095)));
      write_reg(sfmi_pkg::CFG_FLATS_PER_SEASON, 16'($urandom_range(0, 65535)));
      write_reg(sfmi_pkg::CFG_SEASONS_IN_USE, seasons);
      write_reg(sfmi_pkg::CFG_MISS_LIMIT, 16'($urandom_range(1, 255)));
    end
  endtask

  task automatic run_phase(int n_items);
    int        sent, batch_left;
    bit        tx_gappy;
    flat_req_t r;
    sent = 0;
    batch_left = 0;
    tx_gappy = 1'b0;
    while (sent < n_items) begin
      if (batch_left == 0) begin
        batch_left = $urandom_range(1, 24);
        tx_gappy = ($urandom_range(0, 2) != 0);
        r = random_request(1'b1);
      end else begin
        r = random_request(1'b0);
      end
      batch_left--;
      // The halt is sticky, so keep the miss count in bounds until the end of the run.
      if (r.action == ACT_MAP && miss_q >= limit_q) r.first = 1'b1;
      if (!quiet_tail && tx_gappy && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 7));
      offer(r);
      sent++;
    end
  endtask

  initial begin : stimulus
    flat_req_t r;
    int        i;
    for (i = 0; i < MAX_SEASONS; i++) begin
      win_lo[i] = '0;
      win_hi[i] = '0;
    end

    steer_tab.push_back(typed(image_row(1'b1, 16'd0, 32'd0), 32'd0,
                              sfmi_pkg::STAT_HEADER, 9'd0));
    steer_tab.push_back(typed(image_row(1'b0, 16'd5, 32'd77), 32'd0,
                              sfmi_pkg::STAT_UNKNOWN, 9'd0));
    steer_tab.push_back(typed(image_row(1'b0, sfmi_pkg::CAM1_CODE_LO, 32'hFFFF_FFFF), 32'd0,
                              sfmi_pkg::STAT_NO_SEASON, 9'd1));
    steer_tab.push_back(typed(load_row(4'd0, 32'd1000, 32'd1999), 32'd0,
                              sfmi_pkg::STAT_LOADED, 9'd1));
    steer_tab.push_back(typed(load_row(4'd1, 32'd0, 32'hFFFF_FFFF), 32'd0,
                              sfmi_pkg::STAT_LOADED, 9'd1));
    steer_tab.push_back(typed(load_row(4'd15, 32'hFFFF_FFFF, 32'd0), 32'd0,
                              sfmi_pkg::STAT_LOADED, 9'd1));
    steer_tab.push_back(cfg_row(sfmi_pkg::CFG_SEASONS_IN_USE, 16'd2));
    steer_tab.push_back(typed(image_row(1'b1, sfmi_pkg::CAM1_CODE_LO, 32'd1500), 32'd1,
                              sfmi_pkg::STAT_MAPPED, 9'd0));
    steer_tab.push_back(image_row(1'b0, sfmi_pkg::CAM1_CODE_HI, 32'd5));
    steer_tab.push_back(typed(image_row(1'b0, sfmi_pkg::CAM2_CODE_LO, 32'd1999), 32'd1,
                              sfmi_pkg::STAT_MAPPED, 9'd0));
    steer_tab.push_back(image_row(1'b0, sfmi_pkg::CAM2_CODE_HI, 32'hFFFF_FFFF));
    steer_tab.push_back(image_row(1'b0, 16'hFFFF, 32'd1000));
    steer_tab.push_back(image_row(1'b0, 16'd9999, 32'd2000));
    steer_tab.push_back(image_row(1'b0, sfmi_pkg::CAM2_CODE_LO - 16'd1, 32'd0));
    steer_tab.push_back(typed(image_row(1'b1, sfmi_pkg::CAM1_CODE_HI + 16'd1, 32'd1200),
                              32'd0, sfmi_pkg::STAT_UNKNOWN, 9'd0));
    steer_tab.push_back(image_row(1'b0, 16'd10250, 32'd1200));
    steer_tab.push_back(image_row(1'b0, 16'd12345, 32'd7));
    steer_tab.push_back(image_row(1'b0, sfmi_pkg::CAM2_CODE_HI + 16'd1, 32'd1999));
    steer_tab.push_back(typed(image_row(1'b1, 16'd0, 32'd1500), 32'd0,
                              sfmi_pkg::STAT_HEADER, 9'd0));
    steer_tab.push_back(typed(image_row(1'b0, 16'd9999, 32'd1500), 32'd0,
                              sfmi_pkg::STAT_UNKNOWN, 9'd0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steer_tab[k]) begin
      case (steer_tab[k].kind)
        ROW_CFG: begin
          wait_drained();
          write_reg(steer_tab[k].reg_idx, steer_tab[k].reg_val);
        end
        ROW_TYPED: offer(steer_tab[k].req, 1'b1, steer_tab[k].want);
        default: offer(steer_tab[k].req);
      endcase
    end

    // Every window entry is written before any setting can search it.
    for (i = 0; i < MAX_SEASONS; i++) begin
      r = random_request(1'b0);
      r.action = ACT_LOAD;
      r.sidx = 4'(i);
      offer(r);
    end

    for (i = 0; i < PHASES; i++) begin
      wait_drained();
      configure_phase(i);
      quiet_tail = (i == PHASES - 1);
      run_phase(PHASE_ITEMS);
    end

    // Build up five misses, then drop the limit so that the next hit halts the block.
    wait_drained();
    write_reg(sfmi_pkg::CFG_SEASONS_IN_USE, 16'd0);
    write_reg(sfmi_pkg::CFG_MISS_LIMIT, 16'd255);
    r = random_request(1'b0);
    r.action = ACT_LOAD;
    r.sidx = 4'd0;
    r.sbeg = 32'd0;
    r.send = 32'hFFFF_FFFF;
    offer(r);
    for (i = 0; i < 5; i++) begin
      r = random_request(1'b1);
      r.first = (i == 0);
      offer(r);
    end
    wait_drained();
    write_reg(sfmi_pkg::CFG_SEASONS_IN_USE, 16'($urandom_range(1, 16)));
    write_reg(sfmi_pkg::CFG_MISS_LIMIT, 16'd0);
    r = random_request(1'b1);
    r.first = 1'b0;
    offer(r);
    for (i = 0; i < HALTED_ITEMS; i++) offer(random_request(1'($urandom_range(0, 1))));

    @(negedge clk);
    in_valid <= 1'b0;
    while (map_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/sfmi_pkg.sv
hw/rtl/sfmi_win_ram.sv
hw/rtl/sfmi_seq_calc.sv
hw/rtl/season_flat_map_indexer.sv
hw/rtl/sfmi_checker.sv
tb/season_flat_map_indexer_tb.sv
